FILE: rtl/core/fpa_pkg.sv
package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int REM_W     = DATA_W;
  localparam int PROD_W    = 2 * DATA_W;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [DATA_W-1:0]         res;
    logic                      cmp;
    logic                      ovf;
    logic                      dbz;
    logic                      neg;
    logic signed [PROD_W-1:0]  prod;
    logic [NUM_W-1:0]          num;
    logic [REM_W-1:0]          rem;
    logic [DATA_W-1:0]         den;
    logic [NUM_W-1:0]          quo;
  } pipe_t;

endpackage

FILE: rtl/core/fpa_front.sv
module fpa_front
  import fpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_in,
  output logic                     ready_up,
  input  logic [3:0]               cmd_in,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     valid_out,
  input  logic                     ready_dn,
  output pipe_t                    data_out
);

  logic  valid_r;
  pipe_t data_r, data_nxt;

  logic [DATA_W:0]        sum, dif, incv, decv;
  logic [NUM_W-1:0]       fi;
  logic signed [DATA_W-1:0] biased;
  logic [DATA_W-1:0]      mag_a, mag_b;
  logic                   gt, eq;
  cmd_t                   cmd;

  assign cmd  = cmd_t'(cmd_in);
  assign sum  = {a[DATA_W-1], a} + {b[DATA_W-1], b};
  assign dif  = {a[DATA_W-1], a} - {b[DATA_W-1], b};
  assign incv = {a[DATA_W-1], a} + (DATA_W+1)'(1);
  assign decv = {a[DATA_W-1], a} - (DATA_W+1)'(1);
  assign fi   = {{FRAC_BITS{a[DATA_W-1]}}, a} << FRAC_BITS;
  // bias negatives so the arithmetic shift truncates toward zero
  assign biased = a + $signed({{(DATA_W-FRAC_BITS){1'b0}}, {FRAC_BITS{a[DATA_W-1]}}});
  assign mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign gt = a > b;
  assign eq = a == b;

  always_comb begin
    data_nxt      = '0;
    data_nxt.cmd  = cmd;
    data_nxt.prod = PROD_W'(a) * PROD_W'(b);
    data_nxt.num  = {mag_a, {FRAC_BITS{1'b0}}};
    data_nxt.den  = mag_b;
    data_nxt.neg  = a[DATA_W-1] ^ b[DATA_W-1];
    data_nxt.dbz  = (cmd == CMD_DIV) && (b == '0);
    case (cmd)
      CMD_ADD: begin
        data_nxt.res = sum[DATA_W-1:0];
        data_nxt.ovf = sum[DATA_W] ^ sum[DATA_W-1];
      end
      CMD_SUB: begin
        data_nxt.res = dif[DATA_W-1:0];
        data_nxt.ovf = dif[DATA_W] ^ dif[DATA_W-1];
      end
      CMD_INC: begin
        data_nxt.res = incv[DATA_W-1:0];
        data_nxt.ovf = incv[DATA_W] ^ incv[DATA_W-1];
      end
      CMD_DEC: begin
        data_nxt.res = decv[DATA_W-1:0];
        data_nxt.ovf = decv[DATA_W] ^ decv[DATA_W-1];
      end
      CMD_FROM_INT: begin
        data_nxt.res = fi[DATA_W-1:0];
        data_nxt.ovf = !((&fi[NUM_W-1:DATA_W-1]) || !(|fi[NUM_W-1:DATA_W-1]));
      end
      CMD_TO_INT: data_nxt.res = DATA_W'(biased >>> FRAC_BITS);
      CMD_GT:     data_nxt.cmp = gt;
      CMD_LT:     data_nxt.cmp = !gt && !eq;
      CMD_GE:     data_nxt.cmp = gt || eq;
      CMD_LE:     data_nxt.cmp = !gt;
      CMD_EQ:     data_nxt.cmp = eq;
      CMD_NE:     data_nxt.cmp = !eq;
      CMD_MIN:    data_nxt.res = gt ? b : a;
      CMD_MAX:    data_nxt.res = gt ? a : b;
      default:    data_nxt.res = '0;
    endcase
  end

  assign ready_up = !valid_r || ready_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

FILE: rtl/core/fpa_div_cell.sv
module fpa_div_cell
  import fpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_in,
  output logic  ready_up,
  input  pipe_t data_in,
  output logic  valid_out,
  input  logic  ready_dn,
  output pipe_t data_out
);

  logic            valid_r;
  pipe_t           data_r, data_nxt;
  logic [REM_W:0]  trial, diff;
  logic            ge;

  // one restoring step: bring down the next numerator bit, subtract if it fits
  assign trial = {data_in.rem, data_in.num[NUM_W-1]};
  assign diff  = trial - {1'b0, data_in.den};
  assign ge    = !diff[REM_W];

  always_comb begin
    data_nxt     = data_in;
    data_nxt.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    data_nxt.num = data_in.num << 1;
    data_nxt.quo = {data_in.quo[NUM_W-2:0], ge};
  end

  assign ready_up = !valid_r || ready_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

FILE: rtl/core/fpa_back.sv
module fpa_back
  import fpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     valid_in,
  output logic                     ready_up,
  input  pipe_t                    data_in,
  output logic                     valid_out,
  input  logic                     ready_dn,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     compare_true,
  output logic                     divide_by_zero,
  output logic                     overflow
);

  logic                valid_r;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic                cmp_r, dbz_r, ovf_r, ovf_nxt;

  logic [PROD_W-1:0]   m, mr, mv;
  logic                rnd;
  logic [NUM_W:0]      qr;
  logic [NUM_W+1:0]    dv;

  assign m   = data_in.prod[PROD_W-1] ? PROD_W'(-data_in.prod) : PROD_W'(data_in.prod);
  assign mr  = (m + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign mv  = data_in.prod[PROD_W-1] ? -mr : mr;

  // round half away from zero: bump when twice the remainder reaches the divisor
  assign rnd = {data_in.rem, 1'b0} >= {1'b0, data_in.den};
  assign qr  = {1'b0, data_in.quo} + (NUM_W+1)'(rnd);
  assign dv  = data_in.neg ? -{1'b0, qr} : {1'b0, qr};

  always_comb begin
    res_nxt = data_in.res;
    ovf_nxt = data_in.ovf;
    case (data_in.cmd)
      CMD_MUL: begin
        res_nxt = mv[DATA_W-1:0];
        ovf_nxt = !((&mv[PROD_W-1:DATA_W-1]) || !(|mv[PROD_W-1:DATA_W-1]));
      end
      CMD_DIV: begin
        if (data_in.dbz) begin
          res_nxt = '0;
          ovf_nxt = 1'b0;
        end else begin
          res_nxt = dv[DATA_W-1:0];
          ovf_nxt = !((&dv[NUM_W+1:DATA_W-1]) || !(|dv[NUM_W+1:DATA_W-1]));
        end
      end
      default: ;
    endcase
  end

  assign ready_up = !valid_r || ready_dn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      res_r <= res_nxt;
      cmp_r <= data_in.cmp;
      dbz_r <= data_in.dbz;
      ovf_r <= ovf_nxt;
    end
  end

  assign valid_out      = valid_r;
  assign result_value   = $signed(res_r);
  assign compare_true   = cmp_r;
  assign divide_by_zero = dbz_r;
  assign overflow       = ovf_r;

endmodule

FILE: rtl/core/fixed_point_q24_8_alu_top.sv
// Signed Q24.8 fixed-point ALU.
// Input channel: in_valid / in_stall with in_command, in_operand_a, in_operand_b.
// An item is taken at a clock edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall with out_result_value, out_compare_true,
// out_divide_by_zero and out_overflow; one result per item, in order.
// Every item, whatever its command, runs through the same pipeline: an operand
// stage (add/sub/compare results and the 32x32 product), a chain of 40 divider
// cells that each settle one quotient bit, and a rounding/output stage.
// Throughput is one item per cycle while out_stall is low, since every stage
// passes its item on in the cycle it takes the next.
// Each stage holds its item while the stage after it is full and stalled, so
// a stalled receiver backs the pipeline up one stage at a time; empty stages
// keep filling, and in_stall rises only once the operand stage is blocked.
// Synchronous active-low reset empties all stages; no result is pending after.
module fixed_point_q24_8_alu_top
  import fpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_command,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_compare_true,
  output logic                     out_divide_by_zero,
  output logic                     out_overflow
);

  pipe_t stage_data  [NUM_W+1];
  logic  stage_valid [NUM_W+1];
  logic  stage_ready [NUM_W+1];
  logic  front_ready;

  fpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .ready_up  (front_ready),
    .cmd_in    (in_command),
    .a         (in_operand_a),
    .b         (in_operand_b),
    .valid_out (stage_valid[0]),
    .ready_dn  (stage_ready[0]),
    .data_out  (stage_data[0])
  );

  assign in_stall = !front_ready;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (stage_valid[i]),
      .ready_up  (stage_ready[i]),
      .data_in   (stage_data[i]),
      .valid_out (stage_valid[i+1]),
      .ready_dn  (stage_ready[i+1]),
      .data_out  (stage_data[i+1])
    );
  end

  fpa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid_in       (stage_valid[NUM_W]),
    .ready_up       (stage_ready[NUM_W]),
    .data_in        (stage_data[NUM_W]),
    .valid_out      (out_valid),
    .ready_dn       (!out_stall),
    .result_value   (out_result_value),
    .compare_true   (out_compare_true),
    .divide_by_zero (out_divide_by_zero),
    .overflow       (out_overflow)
  );

endmodule
